// File: design/asl_pkg.sv
// shared types and constants for the address segment lookup block
// no dependencies; imported by the controller, datapath, top level and checker
package asl_pkg;

   // default sizes, handed to the top level parameters
   localparam int DEF_MAX_SEGMENTS = 256;
   localparam int DEF_ADDR_BITS    = 48;

   // fixed widths of the op and result fields
   localparam int OP_W        = 2;
   localparam int SEG_INDEX_W = 8;
   localparam int STATUS_W    = 3;

   // op codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BELOW = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ABOVE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ORDER = 3'd4;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_PROBE,
      S_COMPARE
   } asl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;       // latch the request fields
      logic exec;          // run clear / append / unused op and load the result
      logic search_init;   // set up the search bounds
      logic probe;         // latch the midpoint and read the table
      logic compare;       // narrow the bounds from the read start
      logic finish;        // load the lookup result
   } asl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_lookup;     // captured op is a lookup
      logic search_done;   // bounds have met
      logic out_free;      // result register can take a new result
   } asl_stat_type;

endpackage

// File: design/asl_ctrl.sv
// controller state machine for the address segment lookup block
// depends on asl_pkg; drives the datapath through asl_cmd_type
module asl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  asl_pkg::asl_stat_type stat,
   output asl_pkg::asl_cmd_type  cmd
);
   import asl_pkg::*;

   asl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.is_lookup) begin
               cmd.search_init = 1'b1;
               state_in        = S_PROBE;
            end else if (stat.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_PROBE: begin
            if (!stat.search_done) begin
               cmd.probe = 1'b1;
               state_in  = S_COMPARE;
            end else if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_PROBE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: design/asl_dp.sv
// datapath for the address segment lookup block: start table memory,
// search bounds, segment bookkeeping and result register; depends on asl_pkg
module asl_dp #(
   parameter int MAX_SEGMENTS = asl_pkg::DEF_MAX_SEGMENTS,
   parameter int ADDR_BITS    = asl_pkg::DEF_ADDR_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [asl_pkg::OP_W-1:0]          req_op,
   input  logic [ADDR_BITS-1:0]              req_seg_start,
   input  logic [ADDR_BITS-1:0]              req_seg_end,
   input  logic [ADDR_BITS-1:0]              req_query_addr,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [asl_pkg::SEG_INDEX_W-1:0]   rsp_seg_index,
   output logic [asl_pkg::STATUS_W-1:0]      rsp_status,
   input  asl_pkg::asl_cmd_type              cmd,
   output asl_pkg::asl_stat_type             stat
);
   import asl_pkg::*;

   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEGMENTS);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   // start table
   logic [ADDR_BITS-1:0] mem [MAX_SEGMENTS];
   logic [ADDR_BITS-1:0] rd_data_ff;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;

   // captured request
   logic [OP_W-1:0]      op_ff;
   logic [ADDR_BITS-1:0] start_ff, end_ff, addr_ff;

   // table bookkeeping
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ADDR_BITS-1:0] last_start_ff, last_start_in;
   logic [ADDR_BITS-1:0] last_end_ff, last_end_in;

   // search bounds
   logic [CNT_W-1:0]     lo_ff, lo_in, hi_ff, hi_in, md_ff, md_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SEG_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]     found_idx;

   // table write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= start_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.probe) begin
         rd_data_ff <= mem[md_in[IDX_W-1:0]];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         start_ff <= req_seg_start;
         end_ff   <= req_seg_end;
         addr_ff  <= req_query_addr;
      end
   end

   // next values of bookkeeping, bounds and result
   always_comb begin
      count_in      = count_ff;
      last_start_in = last_start_ff;
      last_end_in   = last_end_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      md_in         = lo_ff + ((hi_ff - lo_ff) >> 1);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      found_idx     = lo_ff - ONE_CNT;

      // clear, append and unused op
      if (cmd.exec) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = '0;
         rsp_status_in = ST_OK;
         unique case (op_ff)
            OP_CLEAR: begin
               count_in    = '0;
               last_end_in = '0;
            end
            OP_APPEND: begin
               if (count_ff >= MAX_CNT) begin
                  rsp_status_in = ST_FULL;
               end else if (count_ff != '0 && start_ff < last_start_ff) begin
                  rsp_status_in = ST_ORDER;
               end else begin
                  wr_en         = 1'b1;
                  last_start_in = start_ff;
                  last_end_in   = end_ff;
                  count_in      = count_ff + ONE_CNT;
                  rsp_index_in  = SEG_INDEX_W'(count_ff);
               end
            end
            default: begin
            end
         endcase
      end

      // search bounds cover the whole table
      if (cmd.search_init) begin
         lo_in = '0;
         hi_in = count_ff;
      end

      // upper-bound step on the start just read
      if (cmd.compare) begin
         if (rd_data_ff <= addr_ff) begin
            lo_in = md_ff + ONE_CNT;
         end else begin
            hi_in = md_ff;
         end
      end

      // lookup result; the last entry's start is held in last_start
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_index_in  = '0;
         if (lo_ff == '0) begin
            rsp_status_in = ST_BELOW;
         end else if (lo_ff == count_ff && addr_ff > last_start_ff
                      && addr_ff > last_end_ff) begin
            rsp_status_in = ST_ABOVE;
         end else begin
            rsp_status_in = ST_OK;
            rsp_index_in  = SEG_INDEX_W'(found_idx);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         last_end_ff  <= last_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_start_ff <= last_start_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      if (cmd.probe) begin
         md_ff <= md_in;
      end
   end

   // status to the controller
   always_comb begin
      stat.is_lookup   = (op_ff == OP_LOOKUP);
      stat.search_done = !(lo_ff < hi_ff);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_seg_index = rsp_index_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// File: design/address_segment_lookup.sv
// steps: a clear/append item is captured, then run, and its result is loaded into the
// result register once that register is free; a lookup is captured, sets up its search
// bounds, makes P search probes, up to ceil(log2(N + 1)) for N segments (9 at 256),
// each probe one registered table read plus one compare, and loads its result once the
// result register is free; one item at a time, and a new item is taken while the previous
// result waits; synchronous reset empties the table (count and last end to zero) and drops
// any pending result; top level: joins the controller and the datapath; depends on asl_pkg
module address_segment_lookup #(
   parameter int MAX_SEGMENTS = asl_pkg::DEF_MAX_SEGMENTS,
   parameter int ADDR_BITS    = asl_pkg::DEF_ADDR_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [asl_pkg::OP_W-1:0]        req_op,
   input  logic [ADDR_BITS-1:0]            req_seg_start,
   input  logic [ADDR_BITS-1:0]            req_seg_end,
   input  logic [ADDR_BITS-1:0]            req_query_addr,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [asl_pkg::SEG_INDEX_W-1:0] rsp_seg_index,
   output logic [asl_pkg::STATUS_W-1:0]    rsp_status
);
   import asl_pkg::*;

   asl_cmd_type  cmd;
   asl_stat_type stat;

   // sequencer
   asl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table and search datapath
   asl_dp #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_seg_start  (req_seg_start),
      .req_seg_end    (req_seg_end),
      .req_query_addr (req_query_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_seg_index  (rsp_seg_index),
      .rsp_status     (rsp_status),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule

// File: design/asl_checker.sv
// port-level checks for address_segment_lookup, bound to the top level
// depends on asl_pkg
module asl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [asl_pkg::SEG_INDEX_W-1:0] rsp_seg_index,
   input logic [asl_pkg::STATUS_W-1:0]    rsp_status
);
   import asl_pkg::*;

   // no result straight after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seg_index)
                                   && $stable(rsp_status))
      else $error("stalled result changed");

   // one item at a time: input closes after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input open right after a transfer");

   // status is a known code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_BELOW
                    || rsp_status == ST_ABOVE || rsp_status == ST_FULL
                    || rsp_status == ST_ORDER)
      else $error("unknown status code");

   // any failure status carries index zero
   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_seg_index == '0)
      else $error("failure status with non-zero index");

endmodule

bind address_segment_lookup asl_checker u_asl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_seg_index (rsp_seg_index),
   .rsp_status    (rsp_status)
);

// File: sim/tb_address_segment_lookup.sv
// self-checking testbench for address_segment_lookup: clear, append and lookup
// items against a behavioural copy of the segment table; depends on asl_pkg
// and on the address_segment_lookup top level
module tb_address_segment_lookup;
   import asl_pkg::*;

   localparam int MAX_SEGMENTS = DEF_MAX_SEGMENTS;
   localparam int ADDR_BITS    = DEF_ADDR_BITS;
   localparam int RANDOM_ITEMS = 1380;
   localparam int IDLE_LIMIT   = 2000;
   localparam int PRINT_LIMIT  = 40;

   // op code with no function
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   typedef logic [ADDR_BITS-1:0] addr_type;

   typedef struct packed {
      logic [SEG_INDEX_W-1:0] seg_index;
      logic [STATUS_W-1:0]    status;
   } seg_result_type;

   // clock, reset and block inputs, all known from time zero
   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic [OP_W-1:0]   req_op         = OP_CLEAR;
   addr_type          req_seg_start  = '0;
   addr_type          req_seg_end    = '0;
   addr_type          req_query_addr = '0;
   logic              rsp_ready      = 1'b0;
   logic                   req_ready;
   logic                   rsp_valid;
   logic [SEG_INDEX_W-1:0] rsp_seg_index;
   logic [STATUS_W-1:0]    rsp_status;

   // behavioural copy of the segment table
   addr_type    table_starts [MAX_SEGMENTS];
   int unsigned table_count;
   addr_type    table_last_end;

   seg_result_type results_due [$];
   int          fail_count = 0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   int          rsp_hold;
   bit          burst_mode = 1'b0;

   address_segment_lookup #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .ADDR_BITS    (ADDR_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_seg_start  (req_seg_start),
      .req_seg_end    (req_seg_end),
      .req_query_addr (req_query_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_seg_index  (rsp_seg_index),
      .rsp_status     (rsp_status)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // expected result of one item, updating the table copy
   function automatic seg_result_type segment_table_step(input logic [OP_W-1:0] op,
                                                         input addr_type s,
                                                         input addr_type e,
                                                         input addr_type a);
      seg_result_type r;
      int unsigned lo, hi, md;
      r.seg_index = '0;
      r.status    = ST_OK;
      case (op)
         OP_CLEAR: begin
            table_count    = 0;
            table_last_end = '0;
         end
         OP_APPEND: begin
            if (table_count >= MAX_SEGMENTS) begin
               r.status = ST_FULL;
            end else if (table_count > 0 && s < table_starts[table_count-1]) begin
               r.status = ST_ORDER;
            end else begin
               table_starts[table_count] = s;
               table_last_end            = e;
               r.seg_index               = SEG_INDEX_W'(table_count);
               table_count++;
            end
         end
         OP_LOOKUP: begin
            // upper bound: first entry whose start lies above the address
            lo = 0;
            hi = table_count;
            while (lo < hi) begin
               md = lo + ((hi - lo) >> 1);
               if (table_starts[md] <= a) lo = md + 1;
               else hi = md;
            end
            if (lo == 0) begin
               r.status = ST_BELOW;
            end else if (lo == table_count && a > table_starts[lo-1] &&
                         a > table_last_end) begin
               r.status = ST_ABOVE;
            end else begin
               r.seg_index = SEG_INDEX_W'(lo - 1);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic addr_type rand_addr();
      return ADDR_BITS'({$urandom(), $urandom()});
   endfunction

   // next start in ascending order, saturating at the top of the space
   function automatic addr_type next_start(input addr_type prev);
      logic [ADDR_BITS:0] sum;
      addr_type step;
      case ($urandom_range(0, 9))
         0:       step = '0;
         1, 2, 3: step = ADDR_BITS'($urandom_range(1, 64));
         default: step = rand_addr() >> $urandom_range(9, 47);
      endcase
      sum = {1'b0, prev} + step;
      return sum[ADDR_BITS] ? '1 : sum[ADDR_BITS-1:0];
   endfunction

   function automatic addr_type pick_end(input addr_type s);
      case ($urandom_range(0, 5))
         0:       return rand_addr();
         1:       return s;
         2:       return s - 1;
         default: return s + ADDR_BITS'($urandom_range(0, 4096));
      endcase
   endfunction

   // lookup address aimed at the edges of stored segments
   function automatic addr_type pick_lookup_addr();
      addr_type base;
      if (table_count == 0) return rand_addr();
      base = table_starts[$urandom_range(0, table_count - 1)];
      case ($urandom_range(0, 10))
         0:       return base - 1;
         1:       return base + 1;
         2:       return base + ADDR_BITS'($urandom_range(2, 8192));
         3:       return table_last_end;
         4:       return table_last_end + 1;
         5:       return rand_addr();
         6:       return '0;
         7:       return '1;
         8:       return table_starts[table_count-1] + 1;
         default: return base;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (fail_count < PRINT_LIMIT)
         $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // one request transfer; called and left at a falling edge
   task automatic send_item(input logic [OP_W-1:0] op, input addr_type s,
                            input addr_type e, input addr_type a);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_seg_start  <= s;
      req_seg_end    <= e;
      req_query_addr <= a;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      results_due.push_back(segment_table_step(op, s, e, a));
      items_sent++;
      @(negedge clock);
   endtask

   // hold the sender back until every result has come
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(negedge clock);
   endtask

   task automatic send_noise_item();
      addr_type last;
      case ($urandom_range(0, 3))
         0: send_item(OP_SPARE, rand_addr(), rand_addr(), rand_addr());
         1: begin
            // start below the previous one
            last = (table_count > 0) ? table_starts[table_count-1] : '0;
            if (last != '0)
               send_item(OP_APPEND, last - ADDR_BITS'($urandom_range(1, 3)) & ~addr_type'(0),
                         rand_addr(), rand_addr());
            else
               send_item(OP_SPARE, rand_addr(), rand_addr(), rand_addr());
         end
         2: send_item(OP_APPEND, rand_addr(), rand_addr(), rand_addr());
         default: send_item(OP_LOOKUP, rand_addr(), rand_addr(), rand_addr());
      endcase
   endtask

   // run of ascending appends, with the odd broken one mixed in
   task automatic append_sorted_run(input int count);
      addr_type s;
      repeat (count) begin
         if ($urandom_range(0, 15) == 0) begin
            send_noise_item();
         end else begin
            if (table_count == 0) begin
               case ($urandom_range(0, 3))
                  0:       s = '0;
                  1:       s = rand_addr();
                  default: s = rand_addr() >> $urandom_range(1, 47);
               endcase
            end else begin
               s = next_start(table_starts[table_count-1]);
            end
            send_item(OP_APPEND, s, pick_end(s), rand_addr());
         end
      end
   endtask

   // edge cases on a small hand-built table
   task automatic test_directed_cases();
      send_item(OP_CLEAR,  '0, '0, '0);
      send_item(OP_LOOKUP, '0, '0, '0);
      send_item(OP_SPARE,  '1, '1, '1);
      send_item(OP_APPEND, 48'h100, 48'h1ff, '0);
      send_item(OP_APPEND, 48'h100, 48'h180, '0);
      send_item(OP_APPEND, 48'h0ff, 48'h200, '0);
      send_item(OP_APPEND, 48'h400, 48'h4ff, '0);
      send_item(OP_LOOKUP, '0, '0, 48'h0ff);
      send_item(OP_LOOKUP, '0, '0, 48'h100);
      send_item(OP_LOOKUP, '0, '0, 48'h300);
      send_item(OP_LOOKUP, '0, '0, 48'h400);
      send_item(OP_LOOKUP, '0, '0, 48'h4ff);
      send_item(OP_LOOKUP, '0, '0, 48'h500);
      // end below start: the last start itself still counts as found
      send_item(OP_APPEND, 48'h800, '0, '0);
      send_item(OP_LOOKUP, '0, '0, 48'h800);
      send_item(OP_LOOKUP, '0, '0, 48'h801);
      send_item(OP_APPEND, '1, '1, '0);
      send_item(OP_LOOKUP, '0, '0, '1);
      send_item(OP_LOOKUP, '0, '0, '0);
      send_item(OP_CLEAR,  '1, '1, '1);
      send_item(OP_APPEND, '0, '0, '1);
      send_item(OP_LOOKUP, '1, '1, '0);
      send_item(OP_LOOKUP, '0, '0, 48'h1);
      send_item(OP_CLEAR,  '0, '0, '0);
      send_item(OP_LOOKUP, '0, '0, 48'h123);
   endtask

   // fill every slot, then append past the end and search the full depth
   task automatic test_full_table();
      send_item(OP_CLEAR, rand_addr(), rand_addr(), rand_addr());
      append_sorted_run(MAX_SEGMENTS + 8);
      while (table_count < MAX_SEGMENTS) append_sorted_run(1);
      send_item(OP_APPEND, '1, rand_addr(), rand_addr());
      send_item(OP_APPEND, '0, rand_addr(), rand_addr());
      send_item(OP_LOOKUP, '0, '0, table_starts[0]);
      send_item(OP_LOOKUP, '0, '0, table_starts[MAX_SEGMENTS/2]);
      send_item(OP_LOOKUP, '0, '0, table_starts[MAX_SEGMENTS-1]);
      repeat (12) send_item(OP_LOOKUP, rand_addr(), rand_addr(), pick_lookup_addr());
   endtask

   // random clear / append / lookup sequences
   task automatic test_random_sequences();
      int stop_at;
      int n_app;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         burst_mode = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) != 0)
            send_item(OP_CLEAR, rand_addr(), rand_addr(), rand_addr());
         n_app = ($urandom_range(0, 11) == 0) ? MAX_SEGMENTS + $urandom_range(0, 3)
                                              : $urandom_range(1, 20);
         append_sorted_run(n_app);
         repeat ($urandom_range(1, 30)) begin
            if ($urandom_range(0, 9) == 0) send_noise_item();
            else send_item(OP_LOOKUP, rand_addr(), rand_addr(), pick_lookup_addr());
         end
      end
      burst_mode = 1'b0;
   endtask

   // result side stalls
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!burst_mode && $urandom_range(0, 2) == 0) rsp_hold = pick_gap();
      end
   end

   // compare each result transfer with the oldest one due
   always @(posedge clock) begin
      seg_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            report_mismatch("unexpected result, seg_index", rsp_seg_index, 0);
         end else begin
            want = results_due.pop_front();
            if (rsp_seg_index !== want.seg_index)
               report_mismatch("seg_index", rsp_seg_index, want.seg_index);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      table_count    = 0;
      table_last_end = '0;
      foreach (table_starts[i]) table_starts[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      wait_results_drained();
      test_full_table();
      wait_results_drained();
      test_random_sequences();
      wait_results_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
